[src/ols_pkg.sv]
// ---------------------------------------------------------------------------
// ols_pkg: shared types and constants for the ordered list store
// Request and result layouts, operation codes and status codes.
// ---------------------------------------------------------------------------
package ols_pkg;

  localparam int OLS_CAPACITY    = 32;
  localparam int OLS_VALUE_WIDTH = 32;

  // fixed field widths of the request and result
  localparam int OLS_MODE_W   = 2;
  localparam int OLS_VALUE_W  = 32;
  localparam int OLS_STATUS_W = 2;
  localparam int OLS_HELD_W   = 6;

  // operation codes
  localparam logic [OLS_MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [OLS_MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [OLS_MODE_W-1:0] MODE_LIST   = 2'd2;

  typedef enum logic [OLS_STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [OLS_MODE_W-1:0]         mode;
    logic signed [OLS_VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                       status;
    logic signed [OLS_VALUE_W-1:0] entry_value;
    logic [OLS_HELD_W-1:0]         entries_held;
    logic                          last;
  } rsp_t;

endpackage

[src/ols_ram.sv]
// ---------------------------------------------------------------------------
// ols_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ols_cmp.sv]
// ---------------------------------------------------------------------------
// ols_cmp: shared compare and format unit
// Matches a stored entry against the key and formats it for the result.
// ---------------------------------------------------------------------------
module ols_cmp import ols_pkg::*; #(
  parameter int VALUE_WIDTH = OLS_VALUE_WIDTH
) (
  input  logic [VALUE_WIDTH-1:0]        stored_i,
  input  logic [VALUE_WIDTH-1:0]        key_i,
  output logic                          match_o,
  output logic signed [OLS_VALUE_W-1:0] entry_o
);

  logic signed [VALUE_WIDTH-1:0] stored_s;

  assign stored_s = signed'(stored_i);
  assign match_o  = (stored_i == key_i);
  // sign-extend or cut to the result width
  assign entry_o  = OLS_VALUE_W'(stored_s);

endmodule

[src/ordered_list_store_unit.sv]
// ---------------------------------------------------------------------------
// ordered_list_store_unit: bounded insertion-ordered list of signed values
// Append, remove-all-equal with compaction, and in-order listing.
// ---------------------------------------------------------------------------
// Append and any request on an empty list register their result at the
//   accepting edge and never raise busy.
// Remove and list walk the store through the single RAM read port and hold
//   busy, accepting no new request, until the walk ends. List results stream
//   one per cycle, the last one with last.
// The receiver cannot stall; every result shows for exactly one cycle.
// Reset clears all registers, not the store; unwritten entries are never used.
// ---------------------------------------------------------------------------
module ordered_list_store_unit import ols_pkg::*; #(
  parameter int CAPACITY    = OLS_CAPACITY,
  parameter int VALUE_WIDTH = OLS_VALUE_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic strobe,
  output rsp_t rsp_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_LIST
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;   // entries held
  logic [CntW-1:0]     rd_ptr_q, rd_ptr_d; // next entry to read
  logic [CntW-1:0]     wr_ptr_q, wr_ptr_d; // compaction write slot
  logic                vld_q, vld_d;       // read data is an entry
  logic                hit_q, hit_d;       // remove matched at least once
  logic [VALUE_WIDTH-1:0] key_q, key_d;    // value being removed
  logic                strobe_q, strobe_d;
  rsp_t                rsp_q, rsp_d;

  logic [VALUE_WIDTH-1:0] key_in;
  logic [CntW-1:0]        count_inc;
  logic                   accept;
  logic                   is_full;
  logic                   is_empty;
  logic                   rd_more;

  // RAM ports
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [IdxW-1:0]        ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic                          cmp_match;
  logic signed [OLS_VALUE_W-1:0] cmp_entry;

  ols_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ols_cmp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .stored_i (ram_rdata),
    .key_i    (key_q),
    .match_o  (cmp_match),
    .entry_o  (cmp_entry)
  );

  // input is sign-extended from 32 bits, then held at the store width
  assign key_in    = VALUE_WIDTH'(req_i.value);
  assign count_inc = count_q + 1'b1;
  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign is_full   = (count_q == CntW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign rd_more   = (rd_ptr_q != count_q);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    vld_d    = 1'b0;
    hit_d    = hit_q;
    key_d    = key_q;
    strobe_d = 1'b0;
    rsp_d    = rsp_q;

    ram_we    = 1'b0;
    ram_waddr = count_q[IdxW-1:0];
    ram_wdata = key_in;
    ram_raddr = rd_ptr_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d.entry_value = '0;
          rsp_d.last        = 1'b1;
          case (req_i.mode)
            MODE_APPEND: begin
              strobe_d = 1'b1;
              if (is_full) begin
                rsp_d.status       = ST_FULL;
                rsp_d.entries_held = OLS_HELD_W'(count_q);
              end else begin
                // new entry goes right behind the tail
                ram_we             = 1'b1;
                count_d            = count_inc;
                rsp_d.status       = ST_OK;
                rsp_d.entries_held = OLS_HELD_W'(count_inc);
              end
            end
            MODE_REMOVE, MODE_LIST: begin
              if (is_empty) begin
                strobe_d           = 1'b1;
                rsp_d.status       = ST_EMPTY;
                rsp_d.entries_held = '0;
              end else begin
                rd_ptr_d = '0;
                wr_ptr_d = '0;
                hit_d    = 1'b0;
                key_d    = key_in;
                state_d  = (req_i.mode == MODE_REMOVE) ? S_REMOVE : S_LIST;
              end
            end
            default: begin
              // unused code: no store or count change, no result strobe
            end
          endcase
        end
      end

      S_REMOVE: begin
        if (rd_more) begin
          vld_d    = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (vld_q) begin
          if (cmp_match) begin
            hit_d = 1'b1;
          end else begin
            // keep the entry, shifted down over removed ones
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_q[IdxW-1:0];
            ram_wdata = ram_rdata;
            wr_ptr_d  = wr_ptr_q + 1'b1;
          end
          if (!rd_more) begin
            count_d            = wr_ptr_d;
            strobe_d           = 1'b1;
            rsp_d.status       = hit_d ? ST_OK : ST_NOT_FOUND;
            rsp_d.entry_value  = '0;
            rsp_d.entries_held = OLS_HELD_W'(wr_ptr_d);
            rsp_d.last         = 1'b1;
            state_d            = S_IDLE;
          end
        end
      end

      S_LIST: begin
        if (rd_more) begin
          vld_d    = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (vld_q) begin
          // reads issue back to back, so no read left means final entry
          strobe_d           = 1'b1;
          rsp_d.status       = ST_OK;
          rsp_d.entry_value  = cmp_entry;
          rsp_d.entries_held = OLS_HELD_W'(count_q);
          rsp_d.last         = !rd_more;
          if (!rd_more) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      vld_q    <= 1'b0;
      hit_q    <= 1'b0;
      key_q    <= '0;
      strobe_q <= 1'b0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      vld_q    <= vld_d;
      hit_q    <= hit_d;
      key_q    <= key_d;
      strobe_q <= strobe_d;
      rsp_q    <= rsp_d;
    end
  end

  assign strobe = strobe_q;
  assign rsp_o  = rsp_q;

endmodule
